// ===== rtl/core/dns_query_classifier_core_assert.svh =====
// Assertion macros shared by the classifier core.
`ifndef DNS_QUERY_CLASSIFIER_CORE_ASSERT_SVH
`define DNS_QUERY_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dqc_pkg.sv =====
// Types and constants shared by the DNS query classifier core.
package dqc_pkg;

	localparam int MAX_PACKET  = 512;
	localparam int NAME_LIMIT  = 256;
	localparam int QUEUE_DEPTH = 2;

	localparam int POS_W = $clog2(MAX_PACKET + 1);
	localparam int DC_W  = $clog2(NAME_LIMIT);
	localparam int SUM_W = $clog2(NAME_LIMIT + 64);

	localparam int HDR_BYTES = 12;
	localparam int MIN_QUERY = 17;
	localparam int QTAIL_BYTES = 4;

	localparam int VERDICT_W = 2;
	localparam int FLAGS_W   = 16;
	localparam int QSZ_W     = 10;
	localparam int NLEN_W    = 9;
	localparam int SEEN_W    = 32;
	localparam int OUT_W     = VERDICT_W + FLAGS_W + QSZ_W + NLEN_W + SEEN_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;
	localparam int CALC_W = (POS_W + 1 > QSZ_W) ? POS_W + 1 : QSZ_W;

	localparam logic [15:0] FLAG_QR      = 16'h8000;
	localparam logic [15:0] FLAG_AA      = 16'h0400;
	localparam logic [15:0] FLAG_RA      = 16'h0080;
	localparam logic [15:0] FLAG_RD      = 16'h0100;
	localparam logic [15:0] RCODE_NOTIMP = 16'h0004;
	localparam logic [7:0]  PTR_BITS     = 8'hC0;
	localparam logic [15:0] TYPE_A       = 16'd1;
	localparam logic [15:0] TYPE_AAAA    = 16'd28;
	localparam logic [15:0] CLASS_IN     = 16'd1;
	localparam logic [15:0] QDCOUNT_ONE  = 16'd1;

	localparam int FLAGS_HI_POS = 2;
	localparam int FLAGS_LO_POS = 3;
	localparam int QDC_HI_POS   = 4;
	localparam int QDC_LO_POS   = 5;
	localparam int QR_BIT       = 15;
	localparam int RD_BIT       = 8;

	typedef enum logic [1:0] {
		NAME_LEN,
		NAME_LABEL,
		NAME_DONE
	} name_state_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_DROP,
		VERDICT_NOTIMP,
		VERDICT_EMPTY,
		VERDICT_RESOLVE
	} verdict_t;

	typedef struct packed {
		logic              counted;
		verdict_t          verdict;
		logic              rd;
		logic [POS_W-1:0]  name_end;
	} summary_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

endpackage

// ===== rtl/core/dqc_front.sv =====
// Byte parser: tracks header and question of one packet and classifies it at the last byte.
module dqc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // data_byte[7:0]
	input  logic              s_tlast,
	input  dqc_pkg::q_stat_t  q_stat,
	output logic              push,
	output dqc_pkg::summary_t push_entry
);
	import dqc_pkg::*;

	logic [POS_W-1:0]   pos_q, pos_n;
	logic [15:0]        flags_q, flags_n;
	logic [15:0]        qdc_q, qdc_n;
	logic [5:0]         lrem_q, lrem_n;
	logic [DC_W-1:0]    dchars_q, dchars_n;
	logic [POS_W-1:0]   nend_q, nend_n;
	name_state_t        nstate_q, nstate_n;
	logic [31:0]        tcw_q, tcw_n;
	logic               bad_q, bad_n;

	logic               accept;
	logic               take;
	logic               in_name;
	logic               is_zero;
	logic               is_ptr;
	logic               over;
	logic               start_label;
	logic [POS_W-1:0]   tail_off;
	logic               counted;
	logic               ok;
	logic [15:0]        qtype;
	logic [15:0]        qclass;
	verdict_t           verdict;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign take     = pos_q < POS_W'(MAX_PACKET);
	assign in_name  = take && (pos_q >= POS_W'(HDR_BYTES)) && !bad_q;
	assign is_zero  = s_tdata == 8'h00;
	assign is_ptr   = (s_tdata & PTR_BITS) != 8'h00;
	assign over     = (SUM_W'(dchars_q) + SUM_W'(s_tdata[5:0]) + SUM_W'(1))
		>= SUM_W'(NAME_LIMIT);
	assign start_label = in_name && (nstate_q == NAME_LEN) && !is_zero && !is_ptr && !over;
	assign tail_off = pos_q - nend_q;

	always_comb begin
		nstate_n = nstate_q;
		case (nstate_q)
			NAME_LEN: begin
				if (in_name && is_zero) begin
					nstate_n = NAME_DONE;
				end else if (start_label) begin
					nstate_n = NAME_LABEL;
				end
			end
			NAME_LABEL: begin
				if (in_name && lrem_q == 6'd1) begin
					nstate_n = NAME_LEN;
				end
			end
			NAME_DONE: nstate_n = NAME_DONE;
			default:   nstate_n = NAME_LEN;
		endcase
	end

	always_comb begin
		pos_n    = take ? pos_q + POS_W'(1) : pos_q;
		flags_n  = flags_q;
		qdc_n    = qdc_q;
		lrem_n   = lrem_q;
		dchars_n = dchars_q;
		nend_n   = nend_q;
		tcw_n    = tcw_q;
		bad_n    = bad_q;
		if (take && (pos_q == POS_W'(FLAGS_HI_POS) || pos_q == POS_W'(FLAGS_LO_POS))) begin
			flags_n = {flags_q[7:0], s_tdata};
		end
		if (take && (pos_q == POS_W'(QDC_HI_POS) || pos_q == POS_W'(QDC_LO_POS))) begin
			qdc_n = {qdc_q[7:0], s_tdata};
		end
		if (in_name && nstate_q == NAME_LEN && !is_zero && (is_ptr || over)) begin
			bad_n = 1'b1;
		end
		if (in_name && nstate_q == NAME_LEN && is_zero) begin
			nend_n = pos_q + POS_W'(1);
		end
		if (start_label) begin
			dchars_n = dchars_q + DC_W'(dchars_q != '0) + DC_W'(s_tdata[5:0]);
			lrem_n   = s_tdata[5:0];
		end
		if (in_name && nstate_q == NAME_LABEL) begin
			lrem_n = lrem_q - 6'd1;
		end
		if (in_name && nstate_q == NAME_DONE && tail_off < POS_W'(QTAIL_BYTES)) begin
			tcw_n = {tcw_q[23:0], s_tdata};
		end
	end

	assign counted = pos_n >= POS_W'(MIN_QUERY);
	assign qtype   = tcw_n[31:16];
	assign qclass  = tcw_n[15:0];
	assign ok = counted && !flags_n[QR_BIT] && (qdc_n == QDCOUNT_ONE) && !bad_n &&
		(nstate_n == NAME_DONE) &&
		((POS_W + 1)'(nend_n) + (POS_W + 1)'(QTAIL_BYTES) <= (POS_W + 1)'(pos_n));

	always_comb begin
		if (!ok) begin
			verdict = VERDICT_DROP;
		end else if (qclass != CLASS_IN || (qtype != TYPE_A && qtype != TYPE_AAAA)) begin
			verdict = VERDICT_NOTIMP;
		end else if (qtype == TYPE_AAAA) begin
			verdict = VERDICT_EMPTY;
		end else begin
			verdict = VERDICT_RESOLVE;
		end
	end

	assign push = accept && s_tlast;
	assign push_entry = '{counted: counted, verdict: verdict,
		rd: flags_n[RD_BIT], name_end: nend_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			flags_q  <= '0;
			qdc_q    <= '0;
			lrem_q   <= '0;
			dchars_q <= '0;
			nend_q   <= '0;
			nstate_q <= NAME_LEN;
			tcw_q    <= '0;
			bad_q    <= 1'b0;
		end else if (accept && s_tlast) begin
			pos_q    <= '0;
			flags_q  <= '0;
			qdc_q    <= '0;
			lrem_q   <= '0;
			dchars_q <= '0;
			nend_q   <= '0;
			nstate_q <= NAME_LEN;
			tcw_q    <= '0;
			bad_q    <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_n;
			flags_q  <= flags_n;
			qdc_q    <= qdc_n;
			lrem_q   <= lrem_n;
			dchars_q <= dchars_n;
			nend_q   <= nend_n;
			nstate_q <= nstate_n;
			tcw_q    <= tcw_n;
			bad_q    <= bad_n;
		end
	end

endmodule

// ===== rtl/core/dqc_queue.sv =====
// Short queue of packet summaries between the parser and the reply stage.
module dqc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dqc_pkg::summary_t push_entry,
	input  logic              pop,
	output dqc_pkg::q_stat_t  q_stat,
	output dqc_pkg::summary_t head
);
	import dqc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	summary_t          ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign q_stat.full  = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign q_stat.valid = cnt_q != '0;
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/dqc_back.sv =====
// Reply stage: builds flags and sizes, counts queries and holds the output register.
module dqc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dqc_pkg::q_stat_t                  q_stat,
	input  dqc_pkg::summary_t                 head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [dqc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import dqc_pkg::*;

	logic                 m_tvalid_q;
	verdict_t             verdict_q;
	logic [FLAGS_W-1:0]   flags_q;
	logic [QSZ_W-1:0]     qsz_q;
	logic [NLEN_W-1:0]    nlen_q;
	logic [SEEN_W-1:0]    seen_q;
	logic [SEEN_W-1:0]    count_q;

	logic                 load;
	logic [SEEN_W-1:0]    count_n;
	logic [15:0]          rd_flag;
	logic [FLAGS_W-1:0]   flags_d;
	logic [CALC_W-1:0]    qsz_full;
	logic [CALC_W-1:0]    nlen_full;
	logic                 keep;

	assign load    = q_stat.valid && (!m_tvalid_q || m_tready);
	assign pop     = load;
	assign count_n = count_q + SEEN_W'(head.counted);
	assign rd_flag = head.rd ? FLAG_RD : 16'h0000;
	assign keep    = head.verdict != VERDICT_DROP;
	assign qsz_full  = CALC_W'(head.name_end) + CALC_W'(QTAIL_BYTES);
	assign nlen_full = CALC_W'(head.name_end) - CALC_W'(HDR_BYTES);

	always_comb begin
		case (head.verdict)
			VERDICT_DROP:    flags_d = '0;
			VERDICT_NOTIMP:  flags_d = FLAG_QR | FLAG_RA | rd_flag | RCODE_NOTIMP;
			VERDICT_EMPTY:   flags_d = FLAG_QR | FLAG_RA | rd_flag;
			VERDICT_RESOLVE: flags_d = FLAG_QR | FLAG_AA | FLAG_RA | rd_flag;
			default:         flags_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q <= head.verdict;
			flags_q   <= flags_d;
			qsz_q     <= keep ? qsz_full[QSZ_W-1:0] : '0;
			nlen_q    <= keep ? nlen_full[NLEN_W-1:0] : '0;
			seen_q    <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			count_q    <= '0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				count_q    <= count_n;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, seen_q, nlen_q, qsz_q, flags_q, verdict_q};

endmodule

// ===== rtl/core/dns_query_classifier_core.sv =====
// Top level of the DNS query classifier: parser, summary queue and reply stage.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last
// m_*      out  m_tvalid/m_tready  m_tdata = verdict, reply_flags, question_size,
//                                            name_wire_length, queries_seen
//
// One byte per cycle while s_tready is high; the parser updates its state on each accepted byte.
// A result passes from the last byte of its packet through the queue and then the output register.
// The two-entry summary queue sets the stall: s_tready falls only while it is full.
// Reset clears the parser, queue pointers, output valid and the query counter.
`include "dns_query_classifier_core_assert.svh"

module dns_query_classifier_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // data_byte[7:0]
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dqc_pkg::OUT_TDATA_W-1:0]  m_tdata    // verdict[1:0], reply_flags[17:2],
	                                                    // question_size[27:18],
	                                                    // name_wire_length[36:28],
	                                                    // queries_seen[68:37], zeros above
);
	import dqc_pkg::*;

	logic      push;
	summary_t  push_entry;
	logic      pop;
	q_stat_t   q_stat;
	summary_t  head;

	dqc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	dqc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.q_stat     (q_stat),
		.head       (head)
	);

	dqc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`DQC_ASSERT_IMPLY(a_no_push_full, clk, arst_n, push, !q_stat.full, "push into full queue")
	`DQC_ASSERT_NEXT(a_push_visible, clk, arst_n, push, q_stat.valid, "pushed summary lost")
	`DQC_ASSERT_IMPLY(a_drop_zero, clk, arst_n, m_tvalid && (m_tdata[1:0] == VERDICT_DROP), m_tdata[36:2] == '0, "drop carries nonzero fields")
	`DQC_ASSERT_IMPLY(a_aa_resolve, clk, arst_n, m_tvalid, m_tdata[12] == (m_tdata[1:0] == VERDICT_RESOLVE), "AA flag mismatch")

endmodule

// ===== sim/dqc_verdict_checker.sv =====
`timescale 1ns / 100ps
// Predicts DNS query classifier verdicts from the byte stream and checks every result transaction.
module dqc_verdict_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data_byte[7:0]
	input  logic                            s_tlast,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [dqc_pkg::OUT_TDATA_W-1:0] m_tdata,   // verdict[1:0], reply_flags[17:2],
	                                                   // question_size[27:18],
	                                                   // name_wire_length[36:28],
	                                                   // queries_seen[68:37], zeros above
	output int                              fail_count,
	output int                              pending,
	output int                              results_checked
);
	import dqc_pkg::*;

	typedef struct packed {
		verdict_t           verdict;
		logic [FLAGS_W-1:0] flags;
		logic [QSZ_W-1:0]   qsize;
		logic [NLEN_W-1:0]  name_len;
		logic [SEEN_W-1:0]  seen;
	} verdict_rec_t;

	verdict_rec_t verdict_q[$];
	verdict_rec_t oldest;

	logic [POS_W-1:0]  byte_pos;
	logic [15:0]       req_flags;
	logic [15:0]       qd_count;
	logic [5:0]        label_left;
	logic [DC_W:0]     name_chars;
	logic [POS_W-1:0]  name_end;
	name_state_t       name_phase;
	logic [31:0]       type_class;
	logic              name_bad;
	logic [SEEN_W-1:0] query_count;

	task automatic clear_packet();
		byte_pos   = '0;
		req_flags  = '0;
		qd_count   = '0;
		label_left = '0;
		name_chars = '0;
		name_end   = '0;
		name_phase = NAME_LEN;
		type_class = '0;
		name_bad   = 1'b0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic fin);
		int           pos;
		verdict_rec_t rec;
		logic [15:0]  qtype;
		logic [15:0]  qclass;
		logic [15:0]  rd;
		pos = int'(byte_pos);
		if (pos < MAX_PACKET) begin
			if (pos == FLAGS_HI_POS || pos == FLAGS_LO_POS)
				req_flags = {req_flags[7:0], b};
			else if (pos == QDC_HI_POS || pos == QDC_LO_POS)
				qd_count = {qd_count[7:0], b};
			if (pos >= HDR_BYTES && !name_bad) begin
				case (name_phase)
					NAME_LEN: begin
						if (b == 8'h00) begin
							name_phase = NAME_DONE;
							name_end   = POS_W'(pos + 1);
						end else if ((b & PTR_BITS) != 8'h00) begin
							name_bad = 1'b1;
						end else if (int'(name_chars) + int'(b) + 1 >= NAME_LIMIT) begin
							name_bad = 1'b1;
						end else begin
							name_chars = (DC_W+1)'(int'(name_chars) +
								(name_chars != 0 ? 1 : 0) + int'(b));
							label_left = b[5:0];
							name_phase = NAME_LABEL;
						end
					end
					NAME_LABEL: begin
						label_left = label_left - 6'd1;
						if (label_left == 6'd0)
							name_phase = NAME_LEN;
					end
					default: begin
						if (pos >= int'(name_end) && pos < int'(name_end) + QTAIL_BYTES)
							type_class = {type_class[23:0], b};
					end
				endcase
			end
			byte_pos = POS_W'(pos + 1);
		end
		if (fin) begin
			rec = '0;
			if (int'(byte_pos) >= MIN_QUERY) begin
				query_count = query_count + SEEN_W'(1);
				if (!req_flags[QR_BIT] && qd_count == QDCOUNT_ONE && !name_bad &&
						name_phase == NAME_DONE &&
						int'(name_end) + QTAIL_BYTES <= int'(byte_pos)) begin
					qtype  = type_class[31:16];
					qclass = type_class[15:0];
					rd     = req_flags & FLAG_RD;
					rec.name_len = NLEN_W'(int'(name_end) - HDR_BYTES);
					rec.qsize    = QSZ_W'(int'(name_end) + QTAIL_BYTES);
					if (qclass != CLASS_IN || (qtype != TYPE_A && qtype != TYPE_AAAA)) begin
						rec.verdict = VERDICT_NOTIMP;
						rec.flags   = FLAG_QR | FLAG_RA | rd | RCODE_NOTIMP;
					end else if (qtype == TYPE_AAAA) begin
						rec.verdict = VERDICT_EMPTY;
						rec.flags   = FLAG_QR | FLAG_RA | rd;
					end else begin
						rec.verdict = VERDICT_RESOLVE;
						rec.flags   = FLAG_QR | FLAG_AA | FLAG_RA | rd;
					end
				end
			end
			rec.seen = query_count;
			verdict_q.push_back(rec);
			clear_packet();
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
				$time, what, want, want, got, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_packet();
			query_count = '0;
			verdict_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t ns: result mismatch, expected none, actual 0x%0h",
						$time, m_tdata);
					fail_count++;
				end else begin
					oldest = verdict_q.pop_front();
					check_field("verdict", 32'(oldest.verdict), 32'(m_tdata[1:0]));
					check_field("reply_flags", 32'(oldest.flags), 32'(m_tdata[17:2]));
					check_field("question_size", 32'(oldest.qsize), 32'(m_tdata[27:18]));
					check_field("name_wire_length", 32'(oldest.name_len),
						32'(m_tdata[36:28]));
					check_field("queries_seen", oldest.seen, m_tdata[68:37]);
					check_field("tdata padding", 32'd0,
						32'(m_tdata[OUT_TDATA_W-1:OUT_W]));
					results_checked++;
				end
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
		end
		pending = verdict_q.size();
	end

endmodule

// ===== sim/tb_dns_query_classifier_core.sv =====
`timescale 1ns / 100ps
// Testbench top for the DNS query classifier core: packet stimulus, flow control and verdict.
module tb_dns_query_classifier_core;
	import dqc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_BYTES   = 180;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic [7:0]             s_tdata  = 8'h00;
	logic                   s_tlast  = 1'b0;
	logic                   m_tready = 1'b0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int results_checked;
	int src_idle;
	int dst_idle;
	int bytes_sent;
	int packets_sent;
	int phase_start;
	int idle_cycles;

	logic [7:0] pkt[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dns_query_classifier_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	dqc_verdict_checker verdict_watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	always @(negedge clk)
		m_tready = ($urandom_range(99) >= dst_idle);

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("dns_query_classifier_core verification failed");
				$finish;
			end
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tlast  = fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			put_byte(pkt[i], i == pkt.size() - 1);
		pkt.delete();
		packets_sent++;
	endtask

	task automatic add_header(input logic [15:0] flags, input logic [15:0] qd);
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(flags[15:8]);
		pkt.push_back(flags[7:0]);
		pkt.push_back(qd[15:8]);
		pkt.push_back(qd[7:0]);
		repeat (6)
			pkt.push_back(8'($urandom));
	endtask

	task automatic add_label(input int len);
		pkt.push_back(8'(len));
		repeat (len)
			pkt.push_back(8'($urandom));
	endtask

	task automatic add_tail(input logic [15:0] qtype, input logic [15:0] qclass);
		pkt.push_back(qtype[15:8]);
		pkt.push_back(qtype[7:0]);
		pkt.push_back(qclass[15:8]);
		pkt.push_back(qclass[7:0]);
	endtask

	task automatic directed_queries();
		// single byte, then one byte short of a minimal query
		pkt.push_back(8'hFF);
		send_packet();
		add_header(FLAG_RD, QDCOUNT_ONE);
		repeat (4)
			pkt.push_back(8'h00);
		send_packet();
		// root name, A, smallest accepted query
		add_header(FLAG_RD, QDCOUNT_ONE);
		pkt.push_back(8'h00);
		add_tail(TYPE_A, CLASS_IN);
		send_packet();
		add_header(16'h0000, QDCOUNT_ONE);
		add_label(3);
		add_label(7);
		pkt.push_back(8'h00);
		add_tail(TYPE_AAAA, CLASS_IN);
		send_packet();
		// unsupported type, then unsupported class
		add_header(16'h7FFF, QDCOUNT_ONE);
		add_label(1);
		pkt.push_back(8'h00);
		add_tail(16'd15, CLASS_IN);
		send_packet();
		add_header(FLAG_RD, QDCOUNT_ONE);
		add_label(5);
		pkt.push_back(8'h00);
		add_tail(TYPE_A, 16'd3);
		send_packet();
		// response bit set, then wrong question counts
		add_header(16'hFFFF, QDCOUNT_ONE);
		add_label(2);
		pkt.push_back(8'h00);
		add_tail(TYPE_A, CLASS_IN);
		send_packet();
		add_header(FLAG_RD, 16'h0000);
		add_label(2);
		pkt.push_back(8'h00);
		add_tail(TYPE_A, CLASS_IN);
		send_packet();
		add_header(FLAG_RD, 16'h0002);
		add_label(2);
		pkt.push_back(8'h00);
		add_tail(TYPE_A, CLASS_IN);
		send_packet();
		add_header(FLAG_RD, 16'h0101);
		add_label(2);
		pkt.push_back(8'h00);
		add_tail(TYPE_AAAA, CLASS_IN);
		send_packet();
		// compression pointer, then reserved length bits
		add_header(FLAG_RD, QDCOUNT_ONE);
		add_label(4);
		pkt.push_back(8'hC0);
		pkt.push_back(8'h0C);
		add_tail(TYPE_A, CLASS_IN);
		send_packet();
		add_header(FLAG_RD, QDCOUNT_ONE);
		pkt.push_back(8'h40);
		repeat (6)
			pkt.push_back(8'h00);
		add_tail(TYPE_A, CLASS_IN);
		send_packet();
		// name one label past the decoded limit
		add_header(FLAG_RD, QDCOUNT_ONE);
		repeat (4)
			add_label(63);
		add_label(1);
		pkt.push_back(8'h00);
		add_tail(TYPE_A, CLASS_IN);
		send_packet();
		// name right at the decoded limit, datagram running past the parse window
		add_header(16'h0000, QDCOUNT_ONE);
		repeat (4)
			add_label(63);
		pkt.push_back(8'h00);
		add_tail(TYPE_A, CLASS_IN);
		while (pkt.size() < MAX_PACKET + 8)
			pkt.push_back(8'($urandom));
		send_packet();
		// name cut off by packet end, then question tail one byte short
		add_header(FLAG_RD, QDCOUNT_ONE);
		pkt.push_back(8'd10);
		repeat (5)
			pkt.push_back(8'($urandom));
		send_packet();
		add_header(FLAG_RD, QDCOUNT_ONE);
		add_label(3);
		pkt.push_back(8'h00);
		pkt.push_back(8'h00);
		pkt.push_back(8'h01);
		pkt.push_back(8'h00);
		send_packet();
		// trailing bytes after the question
		add_header(FLAG_RD, QDCOUNT_ONE);
		add_label(2);
		pkt.push_back(8'h00);
		add_tail(TYPE_A, CLASS_IN);
		repeat (3)
			pkt.push_back(8'($urandom));
		send_packet();
	endtask

	task automatic random_query();
		int          roll;
		int          cut;
		logic [15:0] flags;
		logic [15:0] qd;
		logic [15:0] qtype;
		logic [15:0] qclass;
		roll = $urandom_range(99);
		if (roll >= 92) begin
			repeat ($urandom_range(1, 40))
				pkt.push_back(8'($urandom));
		end else begin
			flags = 16'($urandom);
			if ($urandom_range(9) != 0)
				flags[QR_BIT] = 1'b0;
			qd = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 3)) : QDCOUNT_ONE;
			add_header(flags, qd);
			repeat ($urandom_range(0, 4))
				add_label(($urandom_range(15) == 0) ? $urandom_range(1, 63)
					: $urandom_range(1, 8));
			if ($urandom_range(19) == 0)
				pkt.push_back(8'($urandom_range(64, 255)));
			else
				pkt.push_back(8'h00);
			roll = $urandom_range(9);
			qtype = (roll < 4) ? TYPE_A : (roll < 7) ? TYPE_AAAA : 16'($urandom);
			qclass = ($urandom_range(7) == 0) ? 16'($urandom) : CLASS_IN;
			add_tail(qtype, qclass);
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 3))
					pkt.push_back(8'($urandom));
			if ($urandom_range(9) == 0) begin
				cut = $urandom_range(1, pkt.size());
				while (pkt.size() > cut)
					void'(pkt.pop_back());
			end
		end
		send_packet();
	endtask

	initial begin
		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		src_idle = 24;
		dst_idle = 68;
		directed_queries();
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle = 24;
					dst_idle = 68;
				end
				1: begin
					src_idle = 68;
					dst_idle = 24;
				end
				default: begin
					src_idle = 0;
					dst_idle = 0;
				end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < RANDOM_BYTES / 3)
				random_query();
		end
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		$display("Sent %0d datagrams (%0d payload bytes) under sender-heavy, receiver-heavy",
			packets_sent, bytes_sent);
		$display("and free-running flow control; %0d verdicts compared field by field.",
			results_checked);
		if (fail_count == 0)
			$display("dns_query_classifier_core verification clean");
		else
			$display("dns_query_classifier_core verification failed");
		$finish;
	end

endmodule
